>>> src/tbt_pkg.sv
`default_nettype none

package tbt_pkg;

  // Sample and stream widths
  localparam int SAMPLE_BITS = 12;
  localparam int IN_DATA_W   = 16;
  localparam int TEMP_W      = 16;
  localparam int ERR_W       = 2;
  localparam int OUT_DATA_W  = 24;

  // Configuration registers
  localparam int RES_W      = 20;
  localparam int NOMT_W     = 16;
  localparam int BETA_W     = 14;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_SERIES_RES  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RES = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_TMP = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BETA        = 8'd3;

  localparam logic [RES_W-1:0]  SERIES_RES_RST  = 20'd10000;
  localparam logic [RES_W-1:0]  NOMINAL_RES_RST = 20'd10000;
  localparam logic [NOMT_W-1:0] NOMINAL_TMP_RST = 16'd29815;
  localparam logic [BETA_W-1:0] BETA_RST        = 14'd3950;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_OK   = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL = 2'd1;
  localparam logic [ERR_W-1:0] ERR_ZERO = 2'd2;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  // log2 unit
  localparam int LOG_IN_W      = 20;
  localparam int LOG_E_W       = 5;
  localparam int LOG_FRAC_BITS = 24;
  localparam int LOG_OUT_W     = LOG_E_W + LOG_FRAC_BITS;
  localparam int MANT_W        = 31;
  localparam int LOG_LAT       = 2 + LOG_FRAC_BITS;

  // Back end arithmetic
  localparam int L_W     = 32;
  localparam int MAG_W   = 31;
  localparam int LNP_W   = MAG_W + 30;
  localparam int D_W     = 48;
  localparam int TB_W    = NOMT_W + BETA_W;
  localparam int DIV_W   = 66;
  localparam int DIV_BITS = 17;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [DIV_BITS-1:0] Q_MAX = 17'd60082;
  localparam logic [DIV_BITS:0] KELVIN_OFFSET = 18'd27315;
  localparam logic [TEMP_W-1:0] TEMP_SAT_HI = 16'h7FFF;

  // Back end latency: log unit, eight arithmetic stages, divider, output
  localparam int PIPE_LAT = LOG_LAT + 9 + DIV_BITS;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef struct packed {
    logic [RES_W-1:0]  series_res;
    logic [RES_W-1:0]  nominal_res;
    logic [NOMT_W-1:0] nominal_tmp;
    logic [BETA_W-1:0] beta;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] comp;
    logic [ERR_W-1:0]       err;
  } item_t;

endpackage

`default_nettype wire

>>> src/tbt_front.sv
`default_nettype none

module tbt_front import tbt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_DATA_W-1:0] in_tdata,
  input  wire logic                 pop,
  output item_t                     head,
  output logic                      head_valid
);

  item_t                  q_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_PTR_W:0]   count_r, count_nxt;
  item_t                  item;
  logic                   push, do_pop;
  logic [SAMPLE_BITS-1:0] raw;

  assign raw = in_tdata[SAMPLE_BITS-1:0];

  always_comb begin
    item.raw  = raw;
    item.comp = FULL_SCALE - raw;
    if (raw == FULL_SCALE) begin
      item.err = ERR_FULL;
    end else if (raw == '0) begin
      item.err = ERR_ZERO;
    end else begin
      item.err = ERR_OK;
    end
  end

  assign in_tready  = (count_r != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = q_r[rd_ptr_r];
  assign push       = in_tvalid && in_tready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

`default_nettype wire

>>> src/tbt_log2.sv
`default_nettype none

module tbt_log2 import tbt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [LOG_IN_W-1:0]  v_in,
  output logic      [LOG_OUT_W-1:0] log_out
);

  logic [LOG_IN_W-1:0]      va_r;
  logic [LOG_E_W-1:0]       ea_r;
  logic [LOG_E_W-1:0]       e_msb;
  logic [LOG_IN_W-1:0]      v_fix;
  logic [MANT_W-1:0]        m_r [LOG_FRAC_BITS+1];
  logic [LOG_FRAC_BITS-1:0] f_r [LOG_FRAC_BITS+1];
  logic [LOG_E_W-1:0]       e_r [LOG_FRAC_BITS+1];

  assign v_fix = (v_in == '0) ? LOG_IN_W'(1) : v_in;

  always_comb begin
    e_msb = '0;
    for (int i = 0; i < LOG_IN_W; i++) begin
      if (v_fix[i]) begin
        e_msb = LOG_E_W'(i);
      end
    end
  end

  // Leading one, then normalize to Q1.30
  always_ff @(posedge clk) begin
    if (en) begin
      va_r   <= v_fix;
      ea_r   <= e_msb;
      m_r[0] <= MANT_W'(va_r) << (LOG_E_W'(MANT_W - 1) - ea_r);
      f_r[0] <= '0;
      e_r[0] <= ea_r;
    end
  end

  // One fraction bit per stage: square, renormalize
  for (genvar k = 0; k < LOG_FRAC_BITS; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     top;
    assign sq  = m_r[k] * m_r[k];
    assign top = sq[2*MANT_W-1:MANT_W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1] <= top[MANT_W] ? top[MANT_W:1] : top[MANT_W-1:0];
        f_r[k+1] <= {f_r[k][LOG_FRAC_BITS-2:0], top[MANT_W]};
        e_r[k+1] <= e_r[k];
      end
    end
  end

  assign log_out = {e_r[LOG_FRAC_BITS], f_r[LOG_FRAC_BITS]};

endmodule

`default_nettype wire

>>> src/tbt_back.sv
`default_nettype none

module tbt_back import tbt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire item_t                 head,
  input  wire logic                  head_valid,
  output logic                       pop,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata
);

  logic                 adv;
  logic [PIPE_LAT-1:0]  vld_r;
  logic [ERR_W-1:0]     err_r [PIPE_LAT];
  logic [RES_W-1:0]     r1, ro;
  logic [LOG_OUT_W-1:0] lg_r1, lg_raw, lg_comp, lg_ro;

  logic signed [L_W-1:0] l_r;
  logic                  neg2_r, neg3_r;
  logic [MAG_W-1:0]      mag_r;
  logic [LNP_W-1:0]      lnp_r, lnp_rnd;
  logic signed [L_W-1:0] ln_r;
  logic signed [D_W-1:0] nt_s, ln_s, tp_r, d_r;
  logic [D_W-1:0]        hb_r;
  logic [TB_W-1:0]       tb_r;
  logic [DIV_W-1:0]      n_r, num_r;
  logic [D_W-1:0]        dv7_r;
  logic                  bad7_r;

  logic [DIV_W-1:0]    rem_r [DIV_BITS+1];
  logic [D_W-1:0]      dv_r  [DIV_BITS+1];
  logic [DIV_BITS-1:0] q_r   [DIV_BITS+1];
  logic                bad_r [DIV_BITS+1];
  logic                sat_r [DIV_BITS+1];

  logic [TEMP_W-1:0]   temp_r;
  logic [DIV_BITS:0]   t_diff;

  assign adv = !vld_r[PIPE_LAT-1] || out_tready;
  assign pop = adv;

  assign r1 = (cfg.series_res  == '0) ? RES_W'(1) : cfg.series_res;
  assign ro = (cfg.nominal_res == '0) ? RES_W'(1) : cfg.nominal_res;

  tbt_log2 u_log_r1 (.clk(clk), .en(adv), .v_in(r1), .log_out(lg_r1));
  tbt_log2 u_log_raw (.clk(clk), .en(adv), .v_in(LOG_IN_W'(head.raw)), .log_out(lg_raw));
  tbt_log2 u_log_comp (.clk(clk), .en(adv), .v_in(LOG_IN_W'(head.comp)), .log_out(lg_comp));
  tbt_log2 u_log_ro (.clk(clk), .en(adv), .v_in(ro), .log_out(lg_ro));

  // Valid and error code travel beside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r[0] <= head.err;
      for (int i = 1; i < PIPE_LAT; i++) begin
        err_r[i] <= err_r[i-1];
      end
    end
  end

  // Terms that depend on configuration only
  always_ff @(posedge clk) begin
    hb_r <= (D_W'(cfg.beta) * D_W'(100)) << LOG_FRAC_BITS;
    tb_r <= TB_W'(cfg.nominal_tmp) * TB_W'(cfg.beta);
    n_r  <= (DIV_W'(tb_r) * DIV_W'(100)) << LOG_FRAC_BITS;
  end

  assign lnp_rnd = lnp_r + (LNP_W'(1) << 29);
  assign nt_s    = D_W'(cfg.nominal_tmp);
  assign ln_s    = D_W'(ln_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      l_r    <= L_W'(lg_r1) + L_W'(lg_raw) - L_W'(lg_comp) - L_W'(lg_ro);
      neg2_r <= l_r[L_W-1];
      mag_r  <= l_r[L_W-1] ? MAG_W'(-l_r) : MAG_W'(l_r);
      neg3_r <= neg2_r;
      lnp_r  <= LNP_W'(mag_r) * LNP_W'(LN2_Q30);
      ln_r   <= neg3_r ? -L_W'(lnp_rnd[LNP_W-1:30]) : L_W'(lnp_rnd[LNP_W-1:30]);
      tp_r   <= nt_s * ln_s;
      d_r    <= $signed(hb_r) + tp_r;
      bad7_r <= d_r[D_W-1] || (d_r == '0);
      dv7_r  <= (d_r[D_W-1] || (d_r == '0)) ? D_W'(1) : d_r;
      num_r  <= n_r + DIV_W'(d_r[D_W-1:1]);
      rem_r[0] <= num_r;
      dv_r[0]  <= dv7_r;
      q_r[0]   <= '0;
      bad_r[0] <= bad7_r;
      sat_r[0] <= num_r >= (DIV_W'(dv7_r) << DIV_BITS);
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
    logic [DIV_W-1:0] sub;
    logic             ge;
    assign sub = DIV_W'(dv_r[j]) << (DIV_BITS - 1 - j);
    assign ge  = rem_r[j] >= sub;
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1] <= ge ? rem_r[j] - sub : rem_r[j];
        q_r[j+1]   <= {q_r[j][DIV_BITS-2:0], ge};
        dv_r[j+1]  <= dv_r[j];
        bad_r[j+1] <= bad_r[j];
        sat_r[j+1] <= sat_r[j];
      end
    end
  end

  assign t_diff = {1'b0, q_r[DIV_BITS]} - KELVIN_OFFSET;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (err_r[PIPE_LAT-2] != ERR_OK) begin
        temp_r <= '0;
      end else if (bad_r[DIV_BITS] || sat_r[DIV_BITS] || (q_r[DIV_BITS] > Q_MAX)) begin
        temp_r <= TEMP_SAT_HI;
      end else begin
        temp_r <= t_diff[TEMP_W-1:0];
      end
    end
  end

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tdata  = {(OUT_DATA_W-TEMP_W-ERR_W)'(0), err_r[PIPE_LAT-1], temp_r};

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> vld_r == $past(vld_r))
    else $error("pipeline moved while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (err_r[PIPE_LAT-1] != ERR_OK)) |-> temp_r == '0)
    else $error("error word carries a temperature");

endmodule

`default_nettype wire

>>> src/thermistor_beta_temperature.sv
// Channel  Ports                          Word
// in       in_tvalid/in_tready/in_tdata   [11:0] raw_sample
// out      out_tvalid/out_tready/out_tdata [15:0] temperature_centi, [17:16] error_code
// cfg      cfg_valid/cfg_ready            cfg_index selects register, cfg_data value
//
// One word per cycle sustained while out_tready is high.
// Latency is set by the log2 squaring chain (24 stages) and the 17-stage divider.
// Synchronous active-low reset clears control; configuration returns to defaults.
// A stalled output freezes the back pipeline; the four-entry queue keeps taking input until full.
`default_nettype none

module thermistor_beta_temperature import tbt_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [11:0] raw_sample
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [15:0] temperature_centi, [17:16] error_code
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  item_t head;
  logic  head_valid, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.series_res  <= SERIES_RES_RST;
      cfg_r.nominal_res <= NOMINAL_RES_RST;
      cfg_r.nominal_tmp <= NOMINAL_TMP_RST;
      cfg_r.beta        <= BETA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SERIES_RES:  cfg_r.series_res  <= cfg_data[RES_W-1:0];
        REG_NOMINAL_RES: cfg_r.nominal_res <= cfg_data[RES_W-1:0];
        REG_NOMINAL_TMP: cfg_r.nominal_tmp <= cfg_data[NOMT_W-1:0];
        REG_BETA:        cfg_r.beta        <= cfg_data[BETA_W-1:0];
        default: ;
      endcase
    end
  end

  tbt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  tbt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
